[rtl/core/spi_pkg.sv]
// ---------------------------------------------------------------------------
// spi_pkg: shared types and constants of the snapshot position interpolator
// Transaction payloads, interpolation modes, caps and pipeline depths.
// ---------------------------------------------------------------------------
`default_nettype none

package spi_pkg;

    // Input transaction: one entity with its earliest and latest snapshots
    typedef struct packed {
        logic [1:0]         snapshot_count;
        logic signed [23:0] first_x;
        logic signed [23:0] first_y;
        logic [39:0]        first_time;
        logic signed [23:0] last_x;
        logic signed [23:0] last_y;
        logic [39:0]        last_time;
        logic [39:0]        now_time;
    } item_t;

    // Result transaction: validity and position
    typedef struct packed {
        logic               pos_valid;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
    } result_t;

    // How the position of an entity is formed
    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_ONE,
        MODE_LAST,
        MODE_LERP
    } mode_t;

    // Configuration register indexes
    localparam logic CFG_RENDER_DELAY = 1'b0;
    localparam logic CFG_MAX_EXTRAP   = 1'b1;

    localparam logic [19:0] RENDER_DELAY_RESET = 20'd100000;
    localparam logic [15:0] MAX_EXTRAP_RESET   = 16'd19661;

    // Alpha is Q2.14, one quotient bit per divider stage
    localparam int ALPHA_W    = 16;
    localparam int DIV_STAGES = ALPHA_W;
    localparam int DIV_RW     = 42;
    // Input register, divider, clamp, multiply, output register
    localparam int LATENCY    = DIV_STAGES + 4;

    localparam logic signed [40:0] MIN_GAP_US = 41'sd1000;

    // Squared distance thresholds, Q35.16
    localparam logic [50:0] D2_FAR  = 51'd400 << 16;
    localparam logic [50:0] D2_MID  = 51'd100 << 16;
    localparam logic [50:0] D2_NEAR = 51'd25 << 16;

    localparam logic [15:0] CAP_095 = 16'd15565;
    localparam logic [15:0] CAP_100 = 16'd16384;
    localparam logic [15:0] CAP_105 = 16'd17203;

    localparam logic signed [28:0] POS_MAX = 29'sd8388607;
    localparam logic signed [28:0] POS_MIN = -29'sd8388608;

endpackage

`default_nettype wire

[rtl/core/snapshot_position_interpolator.sv]
// ---------------------------------------------------------------------------
// snapshot_position_interpolator: per-entity snapshot interpolation
// Lerps between the earliest and latest snapshot by a clamped, capped factor,
// or takes the single or the latest snapshot as it is.
//  channel   signals                        transaction
//  item      start, busy, item              start high, busy low
//  result    done, result                   done high for one cycle
//  config    cfg_we, cfg_index, cfg_data    cfg_we high
//
//  One transaction may enter every cycle; busy stays low.
//  Each result passes through the input register, the 16-stage factor
//  divider and the clamp, multiply and output stages.
//  Reset clears valid bits and restores the register defaults.
//  The receiver cannot stall; results are presented exactly once.
// ---------------------------------------------------------------------------
`default_nettype none

module snapshot_position_interpolator
    import spi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire item_t       item,
    output logic             done,
    output result_t          result,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [19:0] cfg_data
);

    typedef struct packed {
        mode_t              mode;
        logic signed [23:0] fx;
        logic signed [23:0] fy;
        logic signed [23:0] lx;
        logic signed [23:0] ly;
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        logic [15:0]        maxa;
        logic               num_pos;
        logic               sat;
        logic [15:0]        cap;
    } side_t;

    localparam int LINE = DIV_STAGES - 2;

    logic [19:0] delay_reg;
    logic [15:0] maxa_reg;

    // Stage 1: input register
    logic               s1_v_reg;
    logic [1:0]         s1_cnt_reg;
    logic signed [23:0] s1_fx_reg, s1_fy_reg, s1_lx_reg, s1_ly_reg;
    logic signed [24:0] s1_dx_reg, s1_dy_reg;
    logic signed [40:0] s1_gap_reg;
    logic signed [41:0] s1_num_reg;
    logic [15:0]        s1_maxa_reg;

    // Stage 2: squares and mode
    logic        s2_v_reg;
    side_t       s2_reg, s2_next;
    logic [49:0] s2_dx2_reg, s2_dy2_reg;

    // Stage 3 and the alignment line
    logic        s3_v_reg;
    side_t       s3_reg;
    logic [50:0] d2;
    logic        line_v_reg [LINE];
    side_t       line_reg   [LINE];

    logic [ALPHA_W-1:0] quotient;

    // Clamp, multiply, output
    logic               s18_v_reg;
    side_t              s18_reg;
    logic [15:0]        alpha_reg, alpha_next;
    logic               s19_v_reg;
    side_t              s19_reg;
    logic signed [41:0] px_reg, py_reg;
    logic signed [41:0] tx, ty;
    logic signed [28:0] rx, ry;
    logic               done_reg;
    result_t            result_reg, result_next;

    assign busy = 1'b0;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= RENDER_DELAY_RESET;
            maxa_reg  <= MAX_EXTRAP_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_RENDER_DELAY)
                delay_reg <= cfg_data;
            else
                maxa_reg <= cfg_data[15:0];
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            for (int k = 0; k < LINE; k++)
                line_v_reg[k] <= 1'b0;
            s18_v_reg <= 1'b0;
            s19_v_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            s1_v_reg <= start & ~busy;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            line_v_reg[0] <= s3_v_reg;
            for (int k = 1; k < LINE; k++)
                line_v_reg[k] <= line_v_reg[k-1];
            s18_v_reg <= line_v_reg[LINE-1];
            s19_v_reg <= s18_v_reg;
            done_reg  <= s19_v_reg;
        end
    end

    // Stage 1: capture differences, gap and render offset
    always_ff @(posedge clk)
    begin
        s1_cnt_reg  <= item.snapshot_count;
        s1_fx_reg   <= item.first_x;
        s1_fy_reg   <= item.first_y;
        s1_lx_reg   <= item.last_x;
        s1_ly_reg   <= item.last_y;
        s1_dx_reg   <= {item.last_x[23], item.last_x} - {item.first_x[23], item.first_x};
        s1_dy_reg   <= {item.last_y[23], item.last_y} - {item.first_y[23], item.first_y};
        s1_gap_reg  <= $signed({1'b0, item.last_time} - {1'b0, item.first_time});
        s1_num_reg  <= $signed({2'b00, item.now_time} - {22'd0, delay_reg}
                       - {2'b00, item.first_time});
        s1_maxa_reg <= maxa_reg;
    end

    // Stage 2: pick the mode, flag the factor range
    always_comb
    begin
        s2_next = '0;
        if (s1_cnt_reg == 2'd0)
            s2_next.mode = MODE_NONE;
        else if (s1_cnt_reg == 2'd1)
            s2_next.mode = MODE_ONE;
        else if (s1_gap_reg < MIN_GAP_US)
            s2_next.mode = MODE_LAST;
        else
            s2_next.mode = MODE_LERP;
        s2_next.fx      = s1_fx_reg;
        s2_next.fy      = s1_fy_reg;
        s2_next.lx      = s1_lx_reg;
        s2_next.ly      = s1_ly_reg;
        s2_next.dx      = s1_dx_reg;
        s2_next.dy      = s1_dy_reg;
        s2_next.maxa    = s1_maxa_reg;
        s2_next.num_pos = !s1_num_reg[41] && (s1_num_reg != '0);
        s2_next.sat     = $signed({s1_num_reg[41], s1_num_reg}) >= $signed({s1_gap_reg, 2'b00});
        s2_next.cap     = s1_maxa_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_reg     <= s2_next;
        s2_dx2_reg <= 50'(s1_dx_reg * s1_dx_reg);
        s2_dy2_reg <= 50'(s1_dy_reg * s1_dy_reg);
    end

    // Stage 3: distance cap
    assign d2 = {1'b0, s2_dx2_reg} + {1'b0, s2_dy2_reg};

    always_ff @(posedge clk)
    begin
        s3_reg <= s2_reg;
        if (d2 > D2_FAR)
            s3_reg.cap <= CAP_095;
        else if (d2 > D2_MID)
            s3_reg.cap <= CAP_100;
        else if (d2 > D2_NEAR)
            s3_reg.cap <= CAP_105;
    end

    // Hold side data until the quotient arrives
    always_ff @(posedge clk)
    begin
        line_reg[0] <= s3_reg;
        for (int k = 1; k < LINE; k++)
            line_reg[k] <= line_reg[k-1];
    end

    spi_div u_div (
        .clk      (clk),
        .num      (s1_num_reg[DIV_RW-1:0]),
        .gap      (s1_gap_reg[39:0]),
        .quotient (quotient)
    );

    // Clamp the factor to its limit and the distance cap
    always_comb
    begin
        if (!line_reg[LINE-1].num_pos)
            alpha_next = '0;
        else if (line_reg[LINE-1].sat || (quotient > line_reg[LINE-1].maxa))
            alpha_next = line_reg[LINE-1].maxa;
        else
            alpha_next = quotient;
        if (alpha_next > line_reg[LINE-1].cap)
            alpha_next = line_reg[LINE-1].cap;
    end

    always_ff @(posedge clk)
    begin
        s18_reg   <= line_reg[LINE-1];
        alpha_reg <= alpha_next;
    end

    // Scale the travel by the factor
    always_ff @(posedge clk)
    begin
        s19_reg <= s18_reg;
        px_reg  <= s18_reg.dx * $signed({1'b0, alpha_reg});
        py_reg  <= s18_reg.dy * $signed({1'b0, alpha_reg});
    end

    // Round, offset and saturate
    assign tx = px_reg + 42'sd8192;
    assign ty = py_reg + 42'sd8192;
    assign rx = {{5{s19_reg.fx[23]}}, s19_reg.fx} + {tx[41], tx[41:14]};
    assign ry = {{5{s19_reg.fy[23]}}, s19_reg.fy} + {ty[41], ty[41:14]};

    always_comb
    begin
        result_next = '0;
        case (s19_reg.mode)
            MODE_NONE:
            begin
                result_next = '0;
            end
            MODE_ONE:
            begin
                result_next.pos_valid = 1'b1;
                result_next.pos_x     = s19_reg.fx;
                result_next.pos_y     = s19_reg.fy;
            end
            MODE_LAST:
            begin
                result_next.pos_valid = 1'b1;
                result_next.pos_x     = s19_reg.lx;
                result_next.pos_y     = s19_reg.ly;
            end
            MODE_LERP:
            begin
                result_next.pos_valid = 1'b1;
                if (rx > POS_MAX)
                    result_next.pos_x = POS_MAX[23:0];
                else if (rx < POS_MIN)
                    result_next.pos_x = POS_MIN[23:0];
                else
                    result_next.pos_x = rx[23:0];
                if (ry > POS_MAX)
                    result_next.pos_y = POS_MAX[23:0];
                else if (ry < POS_MIN)
                    result_next.pos_y = POS_MIN[23:0];
                else
                    result_next.pos_y = ry[23:0];
            end
            default:
            begin
                result_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[rtl/core/spi_div.sv]
// ---------------------------------------------------------------------------
// spi_div: pipelined restoring divider for the interpolation factor
// Produces floor(num * 2^14 / gap) for num < 4 * gap, one bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module spi_div
    import spi_pkg::*;
(
    input  wire logic                clk,
    input  wire logic [DIV_RW-1:0]   num,
    input  wire logic [39:0]         gap,
    output logic      [ALPHA_W-1:0]  quotient
);

    logic [DIV_RW-1:0]  r_reg    [DIV_STAGES];
    logic [ALPHA_W-1:0] q_reg    [DIV_STAGES];
    logic [39:0]        gap_reg  [DIV_STAGES];

    logic [DIV_RW-1:0]  r_cur    [DIV_STAGES];
    logic [DIV_RW-1:0]  d_cur    [DIV_STAGES];
    logic [DIV_RW-1:0]  r_next   [DIV_STAGES];
    logic [ALPHA_W-1:0] q_next   [DIV_STAGES];
    logic [39:0]        gap_next [DIV_STAGES];

    // Trial subtract per stage: 2*gap, then gap, then shift and gap
    always_comb
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (k == 0)
            begin
                r_cur[k]    = num;
                d_cur[k]    = {1'b0, gap, 1'b0};
                gap_next[k] = gap;
                q_next[k]   = '0;
            end
            else if (k == 1)
            begin
                r_cur[k]    = r_reg[k-1];
                d_cur[k]    = {2'b00, gap_reg[k-1]};
                gap_next[k] = gap_reg[k-1];
                q_next[k]   = q_reg[k-1];
            end
            else
            begin
                r_cur[k]    = {r_reg[k-1][DIV_RW-2:0], 1'b0};
                d_cur[k]    = {2'b00, gap_reg[k-1]};
                gap_next[k] = gap_reg[k-1];
                q_next[k]   = q_reg[k-1];
            end
            if (r_cur[k] >= d_cur[k])
            begin
                r_next[k] = r_cur[k] - d_cur[k];
                q_next[k] = {q_next[k][ALPHA_W-2:0], 1'b1};
            end
            else
            begin
                r_next[k] = r_cur[k];
                q_next[k] = {q_next[k][ALPHA_W-2:0], 1'b0};
            end
        end
    end

    // Advance every stage each cycle
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            r_reg[k]   <= r_next[k];
            q_reg[k]   <= q_next[k];
            gap_reg[k] <= gap_next[k];
        end
    end

    assign quotient = q_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

[rtl/core/spi_chk.sv]
// ---------------------------------------------------------------------------
// spi_chk: port-level checks of the snapshot position interpolator
// Latency, strobe origin, empty- and single-snapshot content, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module spi_chk
    import spi_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire item_t       item,
    input wire logic        done,
    input wire result_t     result
);

    // Every accepted transaction yields its result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result missing after accepted transaction");

    // No result without a transaction accepted that many cycles before
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching transaction");

    // An entity without snapshots gives an empty, zero result
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(item.snapshot_count, LATENCY) == 2'd0))
        |-> (!result.pos_valid && (result.pos_x == '0) && (result.pos_y == '0)))
        else $error("empty entity gave a position");

    // A single snapshot gives a valid result with its x position unchanged
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(item.snapshot_count, LATENCY) == 2'd1))
        |-> (result.pos_valid && (result.pos_x == $past(item.first_x, LATENCY))))
        else $error("single snapshot position altered");

endmodule

bind snapshot_position_interpolator spi_chk u_spi_chk (.*);

`default_nettype wire
